>>> hdl/wpas_pkg.sv
package wpas_pkg;

   localparam int CordicStages = 16;
   localparam int NumStages = (CordicStages > 24) ? 24 : CordicStages;
   localparam int StageIdxW = (NumStages > 1) ? $clog2(NumStages) : 1;

   localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
   localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [35:0] TwoPiQ30 = 36'sd6746518852;
   localparam logic signed [35:0] CordicKQ30 = 36'sd652032874;
   localparam logic signed [31:0] InvGQ32 = 32'sd437815220;

   localparam logic [2:0] RegPositionGain = 3'd0;
   localparam logic [2:0] RegHeadingGain = 3'd1;
   localparam logic [2:0] RegTiltLimit = 3'd2;
   localparam logic [2:0] RegVelocityLimit = 3'd3;
   localparam logic [2:0] RegDeadZoneRadius = 3'd4;
   localparam logic [2:0] RegYawRateLimit = 3'd5;
   localparam logic [2:0] RegYawFreezeRadius = 3'd6;

   localparam int QueueDepth = 4;
   localparam int QueueIdxW = 2;

   typedef struct packed {
      logic [15:0] position_gain;
      logic [15:0] heading_gain;
      logic [14:0] tilt_limit;
      logic [30:0] velocity_limit;
      logic [30:0] dead_zone_radius;
      logic [14:0] yaw_rate_limit;
      logic [30:0] yaw_freeze_radius;
   } cfg_type;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [15:0] heading;
      logic active;
      logic yaw_on;
   } work_type;

   function automatic logic [35:0] atan_q30(input logic [4:0] i);
      logic [35:0] r;
      begin
         unique case (i)
            5'd0: r = 36'd843314856;
            5'd1: r = 36'd497837829;
            5'd2: r = 36'd263043836;
            5'd3: r = 36'd133525158;
            5'd4: r = 36'd67021686;
            5'd5: r = 36'd33543515;
            5'd6: r = 36'd16775850;
            5'd7: r = 36'd8388437;
            5'd8: r = 36'd4194282;
            5'd9: r = 36'd2097149;
            5'd10: r = 36'd1048575;
            5'd11: r = 36'd524287;
            5'd12: r = 36'd262143;
            5'd13: r = 36'd131071;
            5'd14: r = 36'd65535;
            5'd15: r = 36'd32767;
            5'd16: r = 36'd16383;
            5'd17: r = 36'd8191;
            5'd18: r = 36'd4095;
            5'd19: r = 36'd2047;
            5'd20: r = 36'd1023;
            5'd21: r = 36'd511;
            5'd22: r = 36'd255;
            5'd23: r = 36'd127;
            default: r = 36'd0;
         endcase
         return r;
      end
   endfunction

endpackage

>>> hdl/wpas_front.sv
module wpas_front
   import wpas_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [31:0] current_x,
   input  logic signed [31:0] current_y,
   input  logic signed [15:0] current_heading,
   input  logic signed [31:0] target_x,
   input  logic signed [31:0] target_y,
   output logic out_valid,
   input  logic out_ready,
   output work_type out_work
);

   logic s1_valid_ff, s1_valid_in;
   logic signed [32:0] s1_dx_ff, s1_dy_ff;
   logic signed [15:0] s1_hd_ff;
   logic [31:0] s1_ax_ff, s1_ay_ff;
   logic s1_far_ff;
   logic s1_adv;

   logic s2_valid_ff, s2_valid_in;
   logic signed [32:0] s2_dx_ff, s2_dy_ff;
   logic signed [15:0] s2_hd_ff;
   logic [61:0] s2_sqx_ff, s2_sqy_ff, s2_dz2_ff, s2_fr2_ff;
   logic s2_far_ff;
   logic s2_adv;

   logic signed [32:0] dx_c, dy_c;
   logic [32:0] ax_c, ay_c;
   logic [62:0] d2_c;
   logic s2_active, s2_yaw;

   assign s2_adv = s2_valid_ff && out_ready;
   assign s1_adv = !s2_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in = in_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s1_adv ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      dx_c = 33'(target_x) - 33'(current_x);
      dy_c = 33'(target_y) - 33'(current_y);
      ax_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
      ay_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (in_ready && in_valid) begin
         s1_dx_ff <= dx_c;
         s1_dy_ff <= dy_c;
         s1_hd_ff <= current_heading;
         s1_ax_ff <= ax_c[31:0];
         s1_ay_ff <= ay_c[31:0];
         s1_far_ff <= ax_c[32] | ax_c[31] | ay_c[32] | ay_c[31];
      end
      if (s1_adv && s1_valid_ff) begin
         s2_dx_ff <= s1_dx_ff;
         s2_dy_ff <= s1_dy_ff;
         s2_hd_ff <= s1_hd_ff;
         s2_far_ff <= s1_far_ff;
         s2_sqx_ff <= 62'(s1_ax_ff[30:0] * s1_ax_ff[30:0]);
         s2_sqy_ff <= 62'(s1_ay_ff[30:0] * s1_ay_ff[30:0]);
         s2_dz2_ff <= 62'(cfg.dead_zone_radius * cfg.dead_zone_radius);
         s2_fr2_ff <= 62'(cfg.yaw_freeze_radius * cfg.yaw_freeze_radius);
      end
   end

   always_comb begin
      d2_c = 63'(s2_sqx_ff) + 63'(s2_sqy_ff);
      s2_active = s2_far_ff || (d2_c >= 63'(s2_dz2_ff));
      s2_yaw = s2_far_ff || (d2_c > 63'(s2_fr2_ff));
   end

   assign out_valid = s2_valid_ff;
   assign out_work = '{dx: s2_dx_ff, dy: s2_dy_ff, heading: s2_hd_ff,
                       active: s2_active, yaw_on: s2_yaw};

endmodule

>>> hdl/wpas_queue.sv
module wpas_queue
   import wpas_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  work_type in_work,
   output logic out_valid,
   input  logic out_ready,
   output work_type out_work
);

   work_type mem [QueueDepth];
   logic [QueueIdxW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueIdxW:0] count_ff, count_in;
   logic push, pop;

   assign in_ready = count_ff != (QueueIdxW+1)'(QueueDepth);
   assign out_valid = count_ff != '0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_work = mem[rd_ptr_ff];
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in = count_ff + (QueueIdxW+1)'(push) - (QueueIdxW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_work;
      end
   end

endmodule

>>> hdl/wpas_back.sv
module wpas_back
   import wpas_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  work_type in_work,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [15:0] roll_command,
   output logic signed [15:0] pitch_command,
   output logic signed [15:0] yaw_rate_command
);

   // Pipeline: P prep, NumStages CORDIC stages, M1..M4 arithmetic, then the clamped output.
   localparam int NP = NumStages + 6;

   logic [NP-1:0] v_ff;
   logic adv;
   logic out_valid_ff;

   assign adv = !out_valid_ff || out_ready;
   assign in_ready = adv;

   // Prep stage signals.
   logic signed [35:0] h30_c, zs_c, zb_c;
   logic neg_c;
   logic signed [35:0] bx_c, by_c;
   logic signed [48:0] pvx_c, pvy_c;
   logic signed [41:0] vxr_c, vyr_c;
   logic signed [32:0] vx_c, vy_c;
   logic signed [41:0] vlim_c;

   always_comb begin
      h30_c = 36'(in_work.heading) <<< 18;
      zs_c = h30_c;
      if (zs_c > PiQ30) zs_c = zs_c - TwoPiQ30;
      else if (zs_c < -PiQ30) zs_c = zs_c + TwoPiQ30;
      neg_c = 1'b0;
      if (zs_c > HalfPiQ30) begin
         zs_c = zs_c - PiQ30;
         neg_c = 1'b1;
      end else if (zs_c < -HalfPiQ30) begin
         zs_c = zs_c + PiQ30;
         neg_c = 1'b1;
      end
      bx_c = 36'(in_work.dx);
      by_c = 36'(in_work.dy);
      zb_c = '0;
      if (in_work.dx < 0) begin
         bx_c = -36'(in_work.dx);
         by_c = -36'(in_work.dy);
         zb_c = (in_work.dy >= 0) ? PiQ30 : -PiQ30;
      end
      pvx_c = in_work.dx * $signed({1'b0, cfg.position_gain});
      pvy_c = in_work.dy * $signed({1'b0, cfg.position_gain});
      vxr_c = 42'((pvx_c + 49'sd128) >>> 8);
      vyr_c = 42'((pvy_c + 49'sd128) >>> 8);
      vlim_c = 42'($signed({1'b0, cfg.velocity_limit}));
      if (vxr_c > vlim_c) vx_c = 33'(vlim_c);
      else if (vxr_c < -vlim_c) vx_c = 33'(-vlim_c);
      else vx_c = 33'(vxr_c);
      if (vyr_c > vlim_c) vy_c = 33'(vlim_c);
      else if (vyr_c < -vlim_c) vy_c = 33'(-vlim_c);
      else vy_c = 33'(vyr_c);
   end

   // CORDIC pipeline registers: index 0 is the prep output.
   logic signed [35:0] sx_ff [NumStages+1];
   logic signed [35:0] sy_ff [NumStages+1];
   logic signed [35:0] sz_ff [NumStages+1];
   logic signed [35:0] bxs_ff [NumStages+1];
   logic signed [35:0] bys_ff [NumStages+1];
   logic signed [35:0] bzs_ff [NumStages+1];
   logic signed [32:0] vx_ff [NumStages+1];
   logic signed [32:0] vy_ff [NumStages+1];
   logic signed [35:0] h30_ff [NumStages+1];
   logic neg_ff [NumStages+1];
   logic zero_ff [NumStages+1];
   logic act_ff [NumStages+1];
   logic yaw_ff [NumStages+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0] <= CordicKQ30;
         sy_ff[0] <= '0;
         sz_ff[0] <= zs_c;
         bxs_ff[0] <= bx_c;
         bys_ff[0] <= by_c;
         bzs_ff[0] <= zb_c;
         vx_ff[0] <= vx_c;
         vy_ff[0] <= vy_c;
         h30_ff[0] <= h30_c;
         neg_ff[0] <= neg_c;
         zero_ff[0] <= (in_work.dx == '0) && (in_work.dy == '0);
         act_ff[0] <= in_work.active;
         yaw_ff[0] <= in_work.yaw_on;
      end
   end

   for (genvar i = 0; i < NumStages; i++) begin : g_stage
      localparam logic [4:0] Idx = 5'(i);
      logic signed [35:0] atn;
      assign atn = $signed(atan_q30(Idx));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (sz_ff[i] >= 0) begin
               sx_ff[i+1] <= sx_ff[i] - (sy_ff[i] >>> i);
               sy_ff[i+1] <= sy_ff[i] + (sx_ff[i] >>> i);
               sz_ff[i+1] <= sz_ff[i] - atn;
            end else begin
               sx_ff[i+1] <= sx_ff[i] + (sy_ff[i] >>> i);
               sy_ff[i+1] <= sy_ff[i] - (sx_ff[i] >>> i);
               sz_ff[i+1] <= sz_ff[i] + atn;
            end
            if (bys_ff[i] < 0) begin
               bxs_ff[i+1] <= bxs_ff[i] - (bys_ff[i] >>> i);
               bys_ff[i+1] <= bys_ff[i] + (bxs_ff[i] >>> i);
               bzs_ff[i+1] <= bzs_ff[i] - atn;
            end else begin
               bxs_ff[i+1] <= bxs_ff[i] + (bys_ff[i] >>> i);
               bys_ff[i+1] <= bys_ff[i] - (bxs_ff[i] >>> i);
               bzs_ff[i+1] <= bzs_ff[i] + atn;
            end
            vx_ff[i+1] <= vx_ff[i];
            vy_ff[i+1] <= vy_ff[i];
            h30_ff[i+1] <= h30_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            act_ff[i+1] <= act_ff[i];
            yaw_ff[i+1] <= yaw_ff[i];
         end
      end
   end

   // M1: products of sin/cos with velocity, heading error.
   logic signed [35:0] cs_c, sn_c, err_c;
   logic signed [68:0] m1_cvx_ff, m1_svy_ff, m1_cvy_ff, m1_svx_ff;
   logic signed [35:0] m1_err_ff;
   logic m1_act_ff, m1_yaw_ff;

   always_comb begin
      cs_c = neg_ff[NumStages] ? -sx_ff[NumStages] : sx_ff[NumStages];
      sn_c = neg_ff[NumStages] ? -sy_ff[NumStages] : sy_ff[NumStages];
      err_c = (zero_ff[NumStages] ? 36'sd0 : bzs_ff[NumStages]) - h30_ff[NumStages];
      if (err_c > PiQ30) err_c = err_c - TwoPiQ30;
      else if (err_c < -PiQ30) err_c = err_c + TwoPiQ30;
      if (err_c > PiQ30) err_c = err_c - TwoPiQ30;
      else if (err_c < -PiQ30) err_c = err_c + TwoPiQ30;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_cvx_ff <= cs_c * vx_ff[NumStages];
         m1_svy_ff <= sn_c * vy_ff[NumStages];
         m1_cvy_ff <= cs_c * vy_ff[NumStages];
         m1_svx_ff <= sn_c * vx_ff[NumStages];
         m1_err_ff <= err_c;
         m1_act_ff <= act_ff[NumStages];
         m1_yaw_ff <= yaw_ff[NumStages];
      end
   end

   // M2: body velocities rounded to Q16.16, yaw product.
   logic signed [69:0] sbx_c, sby_c;
   logic signed [39:0] m2_bx_ff, m2_by_ff;
   logic signed [52:0] m2_yp_ff;
   logic m2_act_ff, m2_yaw_ff;

   always_comb begin
      sbx_c = 70'(m1_cvx_ff) + 70'(m1_svy_ff) + (70'sd1 <<< 29);
      sby_c = 70'(m1_cvy_ff) - 70'(m1_svx_ff) + (70'sd1 <<< 29);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_bx_ff <= 40'(sbx_c >>> 30);
         m2_by_ff <= 40'(sby_c >>> 30);
         m2_yp_ff <= m1_err_ff * $signed({1'b0, cfg.heading_gain});
         m2_act_ff <= m1_act_ff;
         m2_yaw_ff <= m1_yaw_ff;
      end
   end

   // M3: tilt products and yaw rounding.
   logic signed [72:0] m3_tp_ff, m3_tr_ff;
   logic signed [27:0] m3_yr_ff;
   logic m3_act_ff, m3_yaw_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_tp_ff <= -(73'(m2_bx_ff) * 73'(InvGQ32));
         m3_tr_ff <= -(73'(m2_by_ff) * 73'(InvGQ32));
         m3_yr_ff <= 28'((m2_yp_ff + (53'sd1 <<< 25)) >>> 26);
         m3_act_ff <= m2_act_ff;
         m3_yaw_ff <= m2_yaw_ff;
      end
   end

   // M4: tilt rounding.
   logic signed [37:0] m4_p_ff, m4_r_ff;
   logic signed [27:0] m4_yr_ff;
   logic m4_act_ff, m4_yaw_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m4_p_ff <= 38'((m3_tp_ff + (73'sd1 <<< 35)) >>> 36);
         m4_r_ff <= 38'((m3_tr_ff + (73'sd1 <<< 35)) >>> 36);
         m4_yr_ff <= m3_yr_ff;
         m4_act_ff <= m3_act_ff;
         m4_yaw_ff <= m3_yaw_ff;
      end
   end

   // M5: clamp and gate.
   logic signed [37:0] tl_c;
   logic signed [27:0] yl_c;
   logic signed [15:0] p_c, r_c, y_c;

   always_comb begin
      tl_c = 38'($signed({1'b0, cfg.tilt_limit}));
      yl_c = 28'($signed({1'b0, cfg.yaw_rate_limit}));
      if (m4_p_ff > tl_c) p_c = 16'(tl_c);
      else if (m4_p_ff < -tl_c) p_c = 16'(-tl_c);
      else p_c = 16'(m4_p_ff);
      if (m4_r_ff > tl_c) r_c = 16'(tl_c);
      else if (m4_r_ff < -tl_c) r_c = 16'(-tl_c);
      else r_c = 16'(m4_r_ff);
      if (m4_yr_ff > yl_c) y_c = 16'(yl_c);
      else if (m4_yr_ff < -yl_c) y_c = 16'(-yl_c);
      else y_c = 16'(m4_yr_ff);
      if (!m4_act_ff) begin
         p_c = '0;
         r_c = '0;
         y_c = '0;
      end else if (!m4_yaw_ff) begin
         y_c = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NP-2:0], in_valid};
      end
      if (adv) begin
         roll_command <= r_c;
         pitch_command <= p_c;
         yaw_rate_command <= y_c;
      end
   end

   assign out_valid_ff = v_ff[NP-1];
   assign out_valid = out_valid_ff;

endmodule

>>> hdl/wpas_csr.sv
module wpas_csr
   import wpas_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   logic [2:0] idx;

   assign idx = paddr[4:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_gain <= 16'd154;
         cfg_ff.heading_gain <= 16'd512;
         cfg_ff.tilt_limit <= 15'd1434;
         cfg_ff.velocity_limit <= 31'd131072;
         cfg_ff.dead_zone_radius <= 31'd6554;
         cfg_ff.yaw_rate_limit <= 15'd4096;
         cfg_ff.yaw_freeze_radius <= 31'd65536;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            RegPositionGain: cfg_ff.position_gain <= pwdata[15:0];
            RegHeadingGain: cfg_ff.heading_gain <= pwdata[15:0];
            RegTiltLimit: cfg_ff.tilt_limit <= pwdata[14:0];
            RegVelocityLimit: cfg_ff.velocity_limit <= pwdata[30:0];
            RegDeadZoneRadius: cfg_ff.dead_zone_radius <= pwdata[30:0];
            RegYawRateLimit: cfg_ff.yaw_rate_limit <= pwdata[14:0];
            RegYawFreezeRadius: cfg_ff.yaw_freeze_radius <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegPositionGain: prdata = {16'd0, cfg_ff.position_gain};
         RegHeadingGain: prdata = {16'd0, cfg_ff.heading_gain};
         RegTiltLimit: prdata = {17'd0, cfg_ff.tilt_limit};
         RegVelocityLimit: prdata = {1'b0, cfg_ff.velocity_limit};
         RegDeadZoneRadius: prdata = {1'b0, cfg_ff.dead_zone_radius};
         RegYawRateLimit: prdata = {17'd0, cfg_ff.yaw_rate_limit};
         RegYawFreezeRadius: prdata = {1'b0, cfg_ff.yaw_freeze_radius};
         default: prdata = '0;
      endcase
   end

endmodule

>>> hdl/waypoint_attitude_setpoint.sv
// Path: front registers s1 and s2, the queue, then the back pipeline
// (16 CORDIC stages plus prep and five arithmetic stages) to the output register.
// Throughput: one item per cycle unless rsp_ready stalls, set by the CORDIC pipeline.
// Reset: synchronous, active high; clears all valid flags and loads register defaults.
module waypoint_attitude_setpoint
   import wpas_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_current_x,
   input  logic signed [31:0] req_current_y,
   input  logic signed [15:0] req_current_heading,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_roll_command,
   output logic signed [15:0] rsp_pitch_command,
   output logic signed [15:0] rsp_yaw_rate_command,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   cfg_type cfg;
   logic f_valid, f_ready, q_valid, q_ready;
   work_type f_work, q_work;

   wpas_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .cfg(cfg)
   );

   wpas_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_valid), .in_ready(req_ready),
      .current_x(req_current_x), .current_y(req_current_y),
      .current_heading(req_current_heading),
      .target_x(req_target_x), .target_y(req_target_y),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   wpas_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
      .out_valid(q_valid), .out_ready(q_ready), .out_work(q_work)
   );

   wpas_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(q_valid), .in_ready(q_ready), .in_work(q_work),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .roll_command(rsp_roll_command), .pitch_command(rsp_pitch_command),
      .yaw_rate_command(rsp_yaw_rate_command)
   );

endmodule
